@@ rtl/jts_pkg.sv @@
// Shared types and constants of the JSON token scanner.
package jts_pkg;

	localparam int POSITION_BITS = 24;
	localparam int Q_DEPTH       = 4;
	localparam int Q_AW          = 2;
	localparam int SLOTS         = 3;

	typedef enum logic [3:0] {
		KIND_END    = 4'd0,
		KIND_WORD   = 4'd1,
		KIND_QUOTED = 4'd2,
		KIND_LBRACE = 4'd3,
		KIND_RBRACE = 4'd4,
		KIND_LBRACK = 4'd5,
		KIND_RBRACK = 4'd6,
		KIND_NUMBER = 4'd7,
		KIND_COMMA  = 4'd8,
		KIND_COLON  = 4'd9
	} kind_t;

	typedef logic [POSITION_BITS-1:0] pos_t;

	typedef struct packed {
		kind_t kind;
		pos_t  offset;
		pos_t  length;
		pos_t  column;
		pos_t  line;
		logic  err;
	} tok_t;

	// Up to three results raised by one text byte, in emission order.
	typedef struct packed {
		logic [SLOTS-1:0]       valid;
		tok_t [SLOTS-1:0]       tok;
	} group_t;

endpackage

@@ rtl/jts_front.sv @@
// Front end: accepts text bytes, tracks scan state and builds result groups.
module jts_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	input  logic             q_full,
	output logic             push,
	output jts_pkg::group_t  grp
);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_WORD   = 2'd2,
		MODE_QUOTED = 2'd3
	} mode_t;

	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam jts_pkg::pos_t POS_MAX = '1;
	localparam jts_pkg::pos_t POS_ONE = jts_pkg::pos_t'(1);

	function automatic jts_pkg::pos_t sat_inc(input jts_pkg::pos_t v);
		return (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_num_byte(input logic [7:0] b);
		return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46) ||
			b == CH_DOT || b == CH_MINUS || b == CH_PLUS;
	endfunction

	function automatic logic ends_word(input logic [7:0] b);
		return is_space(b) || b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACK;
	endfunction

	mode_t         mode_q, mode_n;
	logic          esc_q, esc_n;
	jts_pkg::pos_t pos_q, pos_n, col_q, col_n, line_q, line_n;
	jts_pkg::pos_t so_q, so_n, sc_q, sc_n, sl_q, sl_n;
	jts_pkg::pos_t nxt_pos;
	logic          single;
	jts_pkg::kind_t single_kind;
	logic          accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (grp.valid != '0);

	always_comb begin
		single      = 1'b1;
		single_kind = jts_pkg::KIND_END;
		unique case (text_byte)
			CH_LBRACE: single_kind = jts_pkg::KIND_LBRACE;
			CH_RBRACE: single_kind = jts_pkg::KIND_RBRACE;
			CH_LBRACK: single_kind = jts_pkg::KIND_LBRACK;
			CH_RBRACK: single_kind = jts_pkg::KIND_RBRACK;
			CH_COMMA:  single_kind = jts_pkg::KIND_COMMA;
			CH_COLON:  single_kind = jts_pkg::KIND_COLON;
			default:   single      = 1'b0;
		endcase
	end

	always_comb begin
		nxt_pos = sat_inc(pos_q);
		mode_n  = mode_q;
		esc_n   = esc_q;
		so_n    = so_q;
		sc_n    = sc_q;
		sl_n    = sl_q;
		grp     = '0;

		if (mode_q == MODE_QUOTED) begin
			if (text_byte == CH_QUOTE && !esc_q) begin
				grp.valid[0] = 1'b1;
				grp.tok[0]   = '{jts_pkg::KIND_QUOTED, so_q, nxt_pos - so_q, sc_q, sl_q, 1'b0};
				mode_n       = MODE_IDLE;
				esc_n        = 1'b0;
			end else begin
				esc_n = !esc_q && text_byte == CH_BSLASH;
			end
		end else begin
			// Close a pending number or bare word; the closing byte is rescanned.
			if (mode_q == MODE_NUMBER && !is_num_byte(text_byte)) begin
				grp.valid[0] = 1'b1;
				grp.tok[0]   = '{jts_pkg::KIND_NUMBER, so_q, pos_q - so_q, sc_q, sl_q, 1'b0};
				mode_n       = MODE_IDLE;
			end else if (mode_q == MODE_WORD && ends_word(text_byte)) begin
				grp.valid[0] = 1'b1;
				grp.tok[0]   = '{jts_pkg::KIND_WORD, so_q, pos_q - so_q, sc_q, sl_q, 1'b0};
				mode_n       = MODE_IDLE;
			end
			if (mode_n == MODE_IDLE && !is_space(text_byte)) begin
				priority if (single) begin
					grp.valid[1] = 1'b1;
					grp.tok[1]   = '{single_kind, pos_q, POS_ONE, col_q, line_q, 1'b0};
				end else begin
					so_n = pos_q;
					sc_n = col_q;
					sl_n = line_q;
					if (is_digit(text_byte) || text_byte == CH_DOT) begin
						mode_n = MODE_NUMBER;
					end else if (text_byte == CH_QUOTE) begin
						mode_n = MODE_QUOTED;
						esc_n  = 1'b0;
					end else begin
						mode_n = MODE_WORD;
					end
				end
			end
		end

		pos_n = nxt_pos;
		if (text_byte == CH_LF) begin
			col_n  = POS_ONE;
			line_n = sat_inc(line_q);
		end else begin
			col_n  = sat_inc(col_q);
			line_n = line_q;
		end

		if (end_of_text) begin
			// Flush a pending token, then the end marker, then restart the text.
			unique case (mode_n)
				MODE_NUMBER: begin
					grp.valid[1] = 1'b1;
					grp.tok[1]   = '{jts_pkg::KIND_NUMBER, so_n, pos_n - so_n, sc_n, sl_n, 1'b0};
				end
				MODE_WORD: begin
					grp.valid[1] = 1'b1;
					grp.tok[1]   = '{jts_pkg::KIND_WORD, so_n, pos_n - so_n, sc_n, sl_n, 1'b0};
				end
				MODE_QUOTED: begin
					grp.valid[1] = 1'b1;
					grp.tok[1]   = '{jts_pkg::KIND_QUOTED, so_n, pos_n - so_n, sc_n, sl_n, 1'b1};
				end
				MODE_IDLE: begin
				end
			endcase
			grp.valid[2] = 1'b1;
			grp.tok[2]   = '{jts_pkg::KIND_END, pos_n, '0, col_n, line_n, 1'b0};
			mode_n = MODE_IDLE;
			esc_n  = 1'b0;
			pos_n  = '0;
			col_n  = POS_ONE;
			line_n = POS_ONE;
			so_n   = '0;
			sc_n   = POS_ONE;
			sl_n   = POS_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			esc_q  <= 1'b0;
			pos_q  <= '0;
			col_q  <= POS_ONE;
			line_q <= POS_ONE;
			so_q   <= '0;
			sc_q   <= POS_ONE;
			sl_q   <= POS_ONE;
		end else if (accept) begin
			mode_q <= mode_n;
			esc_q  <= esc_n;
			pos_q  <= pos_n;
			col_q  <= col_n;
			line_q <= line_n;
			so_q   <= so_n;
			sc_q   <= sc_n;
			sl_q   <= sl_n;
		end
	end

endmodule

@@ rtl/jts_queue.sv @@
// Small queue of result groups between the front and back ends.
module jts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jts_pkg::group_t wr_grp,
	input  logic            pop,
	output jts_pkg::group_t rd_grp,
	output logic            empty,
	output logic            full
);

	jts_pkg::group_t             mem_q [jts_pkg::Q_DEPTH];
	logic [jts_pkg::Q_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [jts_pkg::Q_AW:0]      cnt_q;

	assign empty  = cnt_q == '0;
	assign full   = cnt_q == (jts_pkg::Q_AW+1)'(jts_pkg::Q_DEPTH);
	assign rd_grp = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/jts_back.sv @@
// Back end: hands out the results of the head group one word at a time.
module jts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jts_pkg::group_t head,
	input  logic            empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output jts_pkg::tok_t   tok,
	output logic            last
);

	logic [jts_pkg::SLOTS-1:0] done_q;
	logic [jts_pkg::SLOTS-1:0] left;
	logic [jts_pkg::SLOTS-1:0] pick;
	logic [1:0]                idx;
	logic                      take;

	assign left      = head.valid & ~done_q;
	assign out_valid = !empty;
	assign take      = out_valid && !out_stall;

	always_comb begin
		priority if (left[0]) begin
			idx  = 2'd0;
			pick = 3'b001;
		end else if (left[1]) begin
			idx  = 2'd1;
			pick = 3'b010;
		end else begin
			idx  = 2'd2;
			pick = 3'b100;
		end
	end

	assign tok  = head.tok[idx];
	assign last = (left & ~pick) == '0;
	assign pop  = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (take) begin
			done_q <= last ? '0 : (done_q | pick);
		end
	end

endmodule

@@ rtl/json_token_scanner.sv @@
// Top level of the streaming JSON token scanner.
//
// Input channel: one text byte per word (text_byte, end_of_text), taken at a
// rising edge with in_valid high and in_stall low. end_of_text flags the last
// byte of a text; the scanner then flushes and starts afresh on the next byte.
// Output channel: one token per word (kind, offset, length, column, line,
// unterminated_error, last_of_run), taken with out_valid high, out_stall low.
// A byte raises zero to three tokens; last_of_run marks the final one.
// Throughput: one byte per cycle while no byte raises more than one token
// and out_stall stays low; the output side gives one token per cycle while
// out_stall is low. A token's group enters the queue when its byte is taken
// and is shown once the groups ahead have left. A four-group queue sits
// between the byte scanner and the token serialiser, so in_stall rises only
// when that queue is full, i.e. when the serialiser has fallen four groups
// behind, through receiver stalls or through a run of bytes that each raise
// several tokens. Reset clears scan state to line 1, column 1, offset 0 and
// empties the queue; nothing is emitted until bytes arrive.
module json_token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [23:0] token_offset,
	output logic [23:0] token_length,
	output logic [23:0] token_column,
	output logic [23:0] token_line,
	output logic        unterminated_error,
	output logic        last_of_run
);

	jts_pkg::group_t grp, head;
	jts_pkg::tok_t   tok;
	logic            push, pop, empty, full;

	// Scan bytes and build the token group for each.
	jts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.q_full     (full),
		.push       (push),
		.grp        (grp)
	);

	// Hold groups while the receiver stalls or a group is still being serialised.
	jts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (grp),
		.pop    (pop),
		.rd_grp (head),
		.empty  (empty),
		.full   (full)
	);

	// Serialise each group into single token words.
	jts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tok      (tok),
		.last     (last_of_run)
	);

	assign token_kind         = tok.kind;
	assign token_offset       = tok.offset;
	assign token_length       = tok.length;
	assign token_column       = tok.column;
	assign token_line         = tok.line;
	assign unterminated_error = tok.err;

endmodule

@@ rtl/jts_checker.sv @@
// Port-level checks of the JSON token scanner, bound to the top level.
module jts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  text_byte,
	input logic        end_of_text,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  token_kind,
	input logic [23:0] token_offset,
	input logic [23:0] token_length,
	input logic [23:0] token_column,
	input logic [23:0] token_line,
	input logic        unterminated_error,
	input logic        last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(token_offset)
			&& $stable(last_of_run))
		else $error("stalled token word changed");

	a_err_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unterminated_error |-> token_kind == jts_pkg::KIND_QUOTED && !last_of_run)
		else $error("open-quote error not a quoted token followed by end");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == jts_pkg::KIND_END |-> last_of_run && token_length == '0)
		else $error("end token not last or has length");

	a_pos_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_column != '0 && token_line != '0)
		else $error("column or line below one");

endmodule

bind json_token_scanner jts_checker u_jts_checker (.*);

@@ sim/tb_json_token_scanner.sv @@
// Self-checking testbench for the streaming JSON token scanner.
module tb_json_token_scanner;

	timeunit 1ns;
	timeprecision 1ps;

	// Byte values that steer the scanner.
	localparam logic [7:0] ASC_COMMA  = 8'h2C;
	localparam logic [7:0] ASC_COLON  = 8'h3A;
	localparam logic [7:0] ASC_LBRACK = 8'h5B;
	localparam logic [7:0] ASC_RBRACK = 8'h5D;
	localparam logic [7:0] ASC_LBRACE = 8'h7B;
	localparam logic [7:0] ASC_RBRACE = 8'h7D;
	localparam logic [7:0] ASC_QUOTE  = 8'h22;
	localparam logic [7:0] ASC_BSLASH = 8'h5C;
	localparam logic [7:0] ASC_DOT    = 8'h2E;
	localparam logic [7:0] ASC_MINUS  = 8'h2D;
	localparam logic [7:0] ASC_PLUS   = 8'h2B;
	localparam logic [7:0] ASC_LF     = 8'h0A;
	localparam logic [7:0] ASC_CR     = 8'h0D;
	localparam logic [7:0] ASC_TAB    = 8'h09;
	localparam logic [7:0] ASC_SPACE  = 8'h20;

	localparam jts_pkg::pos_t POS_TOP = '1;
	localparam jts_pkg::pos_t POS_ONE = jts_pkg::pos_t'(1);

	// Word count at which the idling pattern swaps, then stops.
	localparam int PHASE_ONE_END = 110;
	localparam int PHASE_TWO_END = 220;
	localparam int WORDS_WANTED  = 300;
	localparam int PRINT_CAP     = 50;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_NUMBER,
		SCAN_WORD,
		SCAN_QUOTED
	} scan_mode_t;

	// One token as the output channel should show it.
	typedef struct packed {
		jts_pkg::kind_t kind;
		jts_pkg::pos_t  offset;
		jts_pkg::pos_t  length;
		jts_pkg::pos_t  column;
		jts_pkg::pos_t  line_no;
		logic           err;
		logic           last;
	} token_exp_t;

	// One row of the directed table: a byte, its end flag and, where the
	// answer is obvious, the tokens typed in by hand.
	typedef struct packed {
		logic [7:0]       b;
		logic             eot;
		logic [1:0]       ntyped;
		token_exp_t [2:0] typed;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  text_byte;
	logic        end_of_text;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  token_kind;
	logic [23:0] token_offset;
	logic [23:0] token_length;
	logic [23:0] token_column;
	logic [23:0] token_line;
	logic        unterminated_error;
	logic        last_of_run;

	// Tokens predicted but not yet seen on the output, oldest first.
	token_exp_t expected_tokens[$];
	stim_row_t  directed_rows[$];
	logic [7:0] text_buf[$];

	// Shadow of the scanner state, kept by the token predictor.
	scan_mode_t    sc_mode;
	logic          sc_escape;
	jts_pkg::pos_t sc_pos;
	jts_pkg::pos_t sc_col;
	jts_pkg::pos_t sc_line;
	jts_pkg::pos_t sc_start_off;
	jts_pkg::pos_t sc_start_col;
	jts_pkg::pos_t sc_start_line;

	int mismatches     = 0;
	int tokens_seen    = 0;
	int words_sent     = 0;
	int texts_sent     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	json_token_scanner uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.text_byte          (text_byte),
		.end_of_text        (end_of_text),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.token_kind         (token_kind),
		.token_offset       (token_offset),
		.token_length       (token_length),
		.token_column       (token_column),
		.token_line         (token_line),
		.unterminated_error (unterminated_error),
		.last_of_run        (last_of_run)
	);

	// 20 ns clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Saturating step of a position counter.
	function automatic jts_pkg::pos_t bump(input jts_pkg::pos_t v);
		return (v == POS_TOP) ? v : v + 1'b1;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == ASC_SPACE || b == ASC_LF || b == ASC_CR || b == ASC_TAB;
	endfunction

	function automatic token_exp_t make_token(input jts_pkg::kind_t k,
		input jts_pkg::pos_t off, input jts_pkg::pos_t len, input jts_pkg::pos_t col,
		input jts_pkg::pos_t ln, input logic err);
		token_exp_t t;
		t.kind    = k;
		t.offset  = off;
		t.length  = len;
		t.column  = col;
		t.line_no = ln;
		t.err     = err;
		t.last    = 1'b0;
		return t;
	endfunction

	// Return the shadow state to line 1, column 1, offset 0.
	function automatic void clear_scan();
		sc_mode       = SCAN_IDLE;
		sc_escape     = 1'b0;
		sc_pos        = '0;
		sc_col        = POS_ONE;
		sc_line       = POS_ONE;
		sc_start_off  = '0;
		sc_start_col  = POS_ONE;
		sc_start_line = POS_ONE;
	endfunction

	// Token predictor: advance the shadow state by one byte and return the
	// tokens that byte raises, in the order they leave the block.
	function automatic void scan_byte(input logic [7:0] b, input logic eot,
		output token_exp_t [2:0] res, output int n);
		jts_pkg::pos_t  next_pos;
		jts_pkg::kind_t punct;
		logic           numeric;
		next_pos = bump(sc_pos);
		n        = 0;
		res      = '0;
		numeric  = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
		           (b >= 8'h41 && b <= 8'h46) || b == ASC_DOT ||
		           b == ASC_MINUS || b == ASC_PLUS;
		if (sc_mode == SCAN_QUOTED) begin
			if (b == ASC_QUOTE && !sc_escape) begin
				res[n] = make_token(jts_pkg::KIND_QUOTED, sc_start_off,
				                    next_pos - sc_start_off, sc_start_col,
				                    sc_start_line, 1'b0);
				n++;
				sc_mode   = SCAN_IDLE;
				sc_escape = 1'b0;
			end else begin
				// An escaped backslash escapes nothing.
				sc_escape = !sc_escape && b == ASC_BSLASH;
			end
		end else begin
			// Close a pending number or bare word; the closing byte is scanned afresh.
			if (sc_mode == SCAN_NUMBER && !numeric) begin
				res[n] = make_token(jts_pkg::KIND_NUMBER, sc_start_off,
				                    sc_pos - sc_start_off, sc_start_col,
				                    sc_start_line, 1'b0);
				n++;
				sc_mode = SCAN_IDLE;
			end else if (sc_mode == SCAN_WORD && (is_blank(b) || b == ASC_COMMA ||
			             b == ASC_RBRACE || b == ASC_RBRACK)) begin
				res[n] = make_token(jts_pkg::KIND_WORD, sc_start_off,
				                    sc_pos - sc_start_off, sc_start_col,
				                    sc_start_line, 1'b0);
				n++;
				sc_mode = SCAN_IDLE;
			end
			if (sc_mode == SCAN_IDLE && !is_blank(b)) begin
				punct = jts_pkg::KIND_END;
				case (b)
					ASC_LBRACE: punct = jts_pkg::KIND_LBRACE;
					ASC_RBRACE: punct = jts_pkg::KIND_RBRACE;
					ASC_LBRACK: punct = jts_pkg::KIND_LBRACK;
					ASC_RBRACK: punct = jts_pkg::KIND_RBRACK;
					ASC_COMMA:  punct = jts_pkg::KIND_COMMA;
					ASC_COLON:  punct = jts_pkg::KIND_COLON;
					default:    punct = jts_pkg::KIND_END;
				endcase
				if (punct != jts_pkg::KIND_END) begin
					res[n] = make_token(punct, sc_pos, POS_ONE, sc_col, sc_line, 1'b0);
					n++;
				end else begin
					if ((b >= 8'h30 && b <= 8'h39) || b == ASC_DOT)
						sc_mode = SCAN_NUMBER;
					else if (b == ASC_QUOTE)
						sc_mode = SCAN_QUOTED;
					else
						sc_mode = SCAN_WORD;
					sc_escape     = 1'b0;
					sc_start_off  = sc_pos;
					sc_start_col  = sc_col;
					sc_start_line = sc_line;
				end
			end
		end

		sc_pos = next_pos;
		if (b == ASC_LF) begin
			sc_col  = POS_ONE;
			sc_line = bump(sc_line);
		end else begin
			sc_col = bump(sc_col);
		end

		// End of text: flush whatever is open, then the end token.
		if (eot) begin
			case (sc_mode)
				SCAN_NUMBER: begin
					res[n] = make_token(jts_pkg::KIND_NUMBER, sc_start_off,
					                    sc_pos - sc_start_off, sc_start_col,
					                    sc_start_line, 1'b0);
					n++;
				end
				SCAN_WORD: begin
					res[n] = make_token(jts_pkg::KIND_WORD, sc_start_off,
					                    sc_pos - sc_start_off, sc_start_col,
					                    sc_start_line, 1'b0);
					n++;
				end
				SCAN_QUOTED: begin
					res[n] = make_token(jts_pkg::KIND_QUOTED, sc_start_off,
					                    sc_pos - sc_start_off, sc_start_col,
					                    sc_start_line, 1'b1);
					n++;
				end
				default: ;
			endcase
			res[n] = make_token(jts_pkg::KIND_END, sc_pos, '0, sc_col, sc_line, 1'b0);
			n++;
			clear_scan();
		end

		if (n > 0)
			res[n-1].last = 1'b1;
	endfunction

	function automatic void add_row(input logic [7:0] b, input logic eot);
		stim_row_t r;
		r     = '0;
		r.b   = b;
		r.eot = eot;
		directed_rows.push_back(r);
	endfunction

	// Attach a hand-typed token to the row added last.
	function automatic void add_typed(input jts_pkg::kind_t k, input int off,
		input int len, input int col, input int ln, input logic err, input logic last);
		stim_row_t r;
		r = directed_rows.pop_back();
		r.typed[r.ntyped]      = make_token(k, jts_pkg::pos_t'(off), jts_pkg::pos_t'(len),
		                                    jts_pkg::pos_t'(col), jts_pkg::pos_t'(ln), err);
		r.typed[r.ntyped].last = last;
		r.ntyped               = r.ntyped + 1'b1;
		directed_rows.push_back(r);
	endfunction

	// Offer one word to the scanner, hold it until taken, then queue the
	// tokens it should raise: the typed ones if any, else the predicted ones.
	task automatic put_word(input logic [7:0] b, input logic eot,
		input logic [1:0] ntyped, input token_exp_t [2:0] typed);
		token_exp_t [2:0] res;
		int               n;
		// Sender idles lightly while the receiver stalls hard, then swap, then flat out.
		if (words_sent < PHASE_ONE_END) begin
			send_idle_pct  = 8;
			recv_stall_pct = 72;
		end else if (words_sent < PHASE_TWO_END) begin
			send_idle_pct  = 72;
			recv_stall_pct = 8;
		end else begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		if (eot)
			texts_sent++;
		scan_byte(b, eot, res, n);
		if (ntyped != 0) begin
			for (int i = 0; i < ntyped; i++)
				expected_tokens.push_back(typed[i]);
		end else begin
			for (int i = 0; i < n; i++)
				expected_tokens.push_back(res[i]);
		end
	endtask

	// Build one random text: mostly JSON-like pieces with random content,
	// sometimes pure byte noise.
	task automatic build_text();
		string numset;
		string word;
		int    pieces;
		int    cnt;
		logic [7:0] c;
		numset = "0123456789abcdefABCDEF.-+";
		text_buf.delete();
		if ($urandom_range(9) == 0) begin
			cnt = $urandom_range(1, 12);
			repeat (cnt)
				text_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		pieces = $urandom_range(1, 8);
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(0, 6))
				0: begin
					case ($urandom_range(0, 3))
						0: text_buf.push_back(ASC_SPACE);
						1: text_buf.push_back(ASC_TAB);
						2: text_buf.push_back(ASC_CR);
						default: text_buf.push_back(ASC_LF);
					endcase
				end
				1: begin
					case ($urandom_range(0, 5))
						0: text_buf.push_back(ASC_LBRACE);
						1: text_buf.push_back(ASC_RBRACE);
						2: text_buf.push_back(ASC_LBRACK);
						3: text_buf.push_back(ASC_RBRACK);
						4: text_buf.push_back(ASC_COMMA);
						default: text_buf.push_back(ASC_COLON);
					endcase
				end
				2: begin
					text_buf.push_back(($urandom_range(0, 4) == 0) ? ASC_DOT :
					                   8'($urandom_range(8'h30, 8'h39)));
					cnt = $urandom_range(0, 5);
					repeat (cnt)
						text_buf.push_back(numset[$urandom_range(0, numset.len() - 1)]);
				end
				3, 4: begin
					text_buf.push_back(ASC_QUOTE);
					cnt = $urandom_range(0, 6);
					repeat (cnt) begin
						case ($urandom_range(0, 3))
							0: begin
								// Escape any byte, a quote or backslash among them.
								text_buf.push_back(ASC_BSLASH);
								text_buf.push_back(8'($urandom_range(0, 255)));
							end
							1: text_buf.push_back(ASC_LF);
							2: begin
								c = 8'($urandom_range(0, 255));
								if (c == ASC_QUOTE || c == ASC_BSLASH)
									text_buf.push_back(ASC_BSLASH);
								text_buf.push_back(c);
							end
							default: text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
						endcase
					end
					// Leave the last string open now and then.
					if (!(p == pieces - 1 && $urandom_range(0, 4) == 0))
						text_buf.push_back(ASC_QUOTE);
				end
				5: begin
					case ($urandom_range(0, 4))
						0: word = "true";
						1: word = "false";
						2: word = "null";
						3: word = "-x";
						default: word = "";
					endcase
					if (word.len() == 0) begin
						cnt = $urandom_range(1, 4);
						repeat (cnt)
							text_buf.push_back(($urandom_range(0, 1) == 1) ?
							                   8'($urandom_range(128, 255)) :
							                   8'($urandom_range(0, 31)));
					end else begin
						for (int i = 0; i < word.len(); i++)
							text_buf.push_back(word[i]);
					end
				end
				default: begin
					// A small object: {"k":<number>}
					text_buf.push_back(ASC_LBRACE);
					text_buf.push_back(ASC_QUOTE);
					text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
					text_buf.push_back(ASC_QUOTE);
					text_buf.push_back(ASC_COLON);
					cnt = $urandom_range(1, 3);
					repeat (cnt)
						text_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
					text_buf.push_back(ASC_RBRACE);
				end
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t ns: token %0d %s: got %0d, want %0d",
			         $time, tokens_seen, what, got, want);
	endtask

	// Receiver side: stall at the rate of the current phase.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Output checker: every token taken must match the oldest expectation.
	always @(posedge clk) begin : token_check
		token_exp_t want;
		if (arst_n && out_valid && !out_stall) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				report_mismatch("arrived unexpected, kind", token_kind, 0);
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.kind)
					report_mismatch("kind", token_kind, want.kind);
				if (token_offset !== want.offset)
					report_mismatch("offset", token_offset, want.offset);
				if (token_length !== want.length)
					report_mismatch("length", token_length, want.length);
				if (token_column !== want.column)
					report_mismatch("column", token_column, want.column);
				if (token_line !== want.line_no)
					report_mismatch("line", token_line, want.line_no);
				if (unterminated_error !== want.err)
					report_mismatch("unterminated_error", unterminated_error, want.err);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", last_of_run, want.last);
			end
		end
	end

	// Main sequence: reset, directed table, random texts, drain, verdict.
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		text_byte   = '0;
		end_of_text = 1'b0;
		clear_scan();

		// Directed text 1: {"\"\\<LF>":-7]<LF>.e+,<00><FF>} closed by end of text.
		// Covers every delimiter but the opening bracket, escapes, an escaped
		// backslash, LF inside a string and in whitespace, a minus starting a bare
		// word, a number closed by a comma, the extreme byte values in a word, and
		// three tokens from one byte.
		add_row(ASC_LBRACE, 1'b0);
		add_typed(jts_pkg::KIND_LBRACE, 0, 1, 1, 1, 1'b0, 1'b1);
		add_row(ASC_QUOTE, 1'b0);
		add_row(ASC_BSLASH, 1'b0);
		add_row(ASC_QUOTE, 1'b0);
		add_row(ASC_BSLASH, 1'b0);
		add_row(ASC_BSLASH, 1'b0);
		add_row(ASC_LF, 1'b0);
		add_row(ASC_QUOTE, 1'b0);
		add_row(ASC_COLON, 1'b0);
		add_row(ASC_MINUS, 1'b0);
		add_row(8'h37, 1'b0);
		add_row(ASC_RBRACK, 1'b0);
		add_row(ASC_LF, 1'b0);
		add_row(ASC_DOT, 1'b0);
		add_row(8'h65, 1'b0);
		add_row(ASC_PLUS, 1'b0);
		add_row(ASC_COMMA, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(ASC_RBRACE, 1'b1);
		// Directed text 2: a number running into end of text.
		add_row(8'h39, 1'b0);
		add_row(8'h30, 1'b1);
		add_typed(jts_pkg::KIND_NUMBER, 0, 2, 1, 1, 1'b0, 1'b0);
		add_typed(jts_pkg::KIND_END, 2, 0, 3, 1, 1'b0, 1'b1);
		// Directed text 3: open quote at end of text raises the error token.
		add_row(ASC_QUOTE, 1'b0);
		add_row(8'h78, 1'b1);
		add_typed(jts_pkg::KIND_QUOTED, 0, 2, 1, 1, 1'b1, 1'b0);
		add_typed(jts_pkg::KIND_END, 2, 0, 3, 1, 1'b0, 1'b1);
		// Directed text 4: whitespace only gives just the end token.
		add_row(ASC_SPACE, 1'b1);
		add_typed(jts_pkg::KIND_END, 1, 0, 2, 1, 1'b0, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			put_word(directed_rows[i].b, directed_rows[i].eot,
			         directed_rows[i].ntyped, directed_rows[i].typed);

		while (words_sent < WORDS_WANTED) begin
			build_text();
			foreach (text_buf[i])
				put_word(text_buf[i], i == text_buf.size() - 1, 2'd0, '0);
		end
		in_valid    <= 1'b0;
		end_of_text <= 1'b0;

		// Drain, then wait for any stray token to show.
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Scanned %0d bytes in %0d texts; %0d tokens compared field by field,",
		         words_sent, texts_sent, tokens_seen);
		$display("with escapes, open quotes at end of text and both sides idling.");
		if (mismatches == 0) begin
			$display("json_token_scanner verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("json_token_scanner verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("timeout with %0d tokens outstanding", expected_tokens.size());
		$display("json_token_scanner verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/jts_pkg.sv
rtl/jts_front.sv
rtl/jts_queue.sv
rtl/jts_back.sv
rtl/json_token_scanner.sv
rtl/jts_checker.sv
sim/tb_json_token_scanner.sv
